>>> sv/fifo_with_priority_extract_defines.svh
// Assertion macros shared by the queue RTL.
`ifndef FIFO_WITH_PRIORITY_EXTRACT_DEFINES_SVH
`define FIFO_WITH_PRIORITY_EXTRACT_DEFINES_SVH

`ifndef ASSERT_OFF
// Plain property, checked on every clock edge outside reset.
`define FWPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication, checked outside reset.
`define FWPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FWPE_ASSERT(lbl, prop, msg)
`define FWPE_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> sv/fwpe_pkg.sv
// Shared types and codes for the priority-extract queue.
package fwpe_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned OP_W    = 2;
  localparam int unsigned PAY_W   = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned BIT_IDX_W = $clog2(PRIO_W);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

  // Result status codes
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                 seed_x;   // start a max search: all live cells are candidates
    logic                 seed_p;   // start a pop: only the head cell is a candidate
    logic                 elim;     // one elimination step on bit bit_idx
    logic [BIT_IDX_W-1:0] bit_idx;  // key bit under test, MSB first
    logic                 shift;    // close the gap at and after the removed slot
    logic                 push;     // write the pushed item into the tail slot
  } fwpe_ctl_t;

endpackage

>>> sv/fwpe_prefix.sv
// Log-depth prefix OR across the cell row (marks every slot at or after the first candidate).
module fwpe_prefix #(
  parameter int unsigned WIDTH = 16
) (
  input  logic [WIDTH-1:0] vec_in,
  output logic [WIDTH-1:0] vec_out
);

  localparam int unsigned LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  wire [WIDTH-1:0] lvl [0:LEVELS];

  assign lvl[0] = vec_in;

  // Kogge-Stone style: level k folds in the bit 2**k places below
  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    for (genvar i = 0; i < WIDTH; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign vec_out = lvl[LEVELS];

endmodule

>>> sv/fwpe_cell.sv
// One queue slot: holds an entry, its candidate flag, and shifts toward the head.
module fwpe_cell #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned IDX         = 0,
  parameter int unsigned SLOT_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fwpe_pkg::fwpe_ctl_t                   ctl,
  input  logic                                  any_hit,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      count,
  input  logic                                  pre_self,
  input  logic                                  pre_prev,
  input  logic [SLOT_BITS-1:0]                  nb_payload,
  input  logic signed [fwpe_pkg::PRIO_W-1:0]    nb_prio,
  input  logic [SLOT_BITS-1:0]                  push_payload,
  input  logic signed [fwpe_pkg::PRIO_W-1:0]    push_prio,
  output logic [SLOT_BITS-1:0]                  payload,
  output logic signed [fwpe_pkg::PRIO_W-1:0]    prio,
  output logic                                  cand,
  output logic                                  hit,
  output logic [SLOT_BITS-1:0]                  sel_payload,
  output logic [fwpe_pkg::PRIO_W-1:0]           sel_prio
);

  import fwpe_pkg::*;

  localparam int unsigned CW      = $clog2(QUEUE_DEPTH + 1);
  localparam logic        IS_HEAD = (IDX == 0);

  logic [SLOT_BITS-1:0]     pay_r, pay_nxt;
  logic signed [PRIO_W-1:0] pri_r, pri_nxt;
  logic                     cand_r, cand_nxt;
  logic                     live, tail, first, key_bit;
  logic [PRIO_W-1:0]        key;

  // slot position against the fill level
  assign live = (CW'(IDX) < count);
  assign tail = (CW'(IDX) == count);

  // offset-binary key so unsigned bit order matches signed order
  assign key     = {~pri_r[PRIO_W-1], pri_r[PRIO_W-2:0]};
  assign key_bit = key[ctl.bit_idx];

  // first candidate in the row is the one removed
  assign first = pre_self & ~pre_prev;

  // candidate flag: seeded, then narrowed one key bit per step
  always_comb begin
    priority if (ctl.seed_x) begin
      cand_nxt = live;
    end else if (ctl.seed_p) begin
      cand_nxt = live & IS_HEAD;
    end else if (ctl.elim && any_hit) begin
      cand_nxt = cand_r & key_bit;
    end else begin
      cand_nxt = cand_r;
    end
  end

  // entry data: tail write on push, take the neighbor's entry on removal
  always_comb begin
    pay_nxt = pay_r;
    pri_nxt = pri_r;
    priority if (ctl.push && tail) begin
      pay_nxt = push_payload;
      pri_nxt = push_prio;
    end else if (ctl.shift && pre_self) begin
      pay_nxt = nb_payload;
      pri_nxt = nb_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= 1'b0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
    pri_r <= pri_nxt;
  end

  assign payload     = pay_r;
  assign prio        = pri_r;
  assign cand        = cand_r;
  assign hit         = cand_r & key_bit;
  assign sel_payload = first ? pay_r : '0;
  assign sel_prio    = first ? pri_r : '0;

endmodule

>>> sv/fifo_with_priority_extract.sv
// Top level of the bounded queue with pop-oldest and remove-highest-priority.
//
// Items come in on in_valid/in_ready with in_opcode, in_payload and in_priority.
// Push appends at the tail, pop removes the oldest entry, extract removes the
// entry of greatest priority (oldest on ties) and closes the gap in order.
// Each item gives one result on out_valid/out_ready: out_status (ok, empty,
// full), the removed entry (zero when none) and out_occupancy after the item.
// One item is worked on at a time. Push, pop, the unused code and an extract
// on an empty queue go from acceptance straight to the apply step, which
// registers the result. Extract on a non-empty queue seeds the cells at
// acceptance; 8 elimination steps follow (one per priority bit, MSB first,
// across all cells at once) and the apply step then reads out and shifts the
// row and registers the result. A new item is accepted as soon as the
// previous one has reached the output register, even if that result has not
// been taken yet. If the receiver stalls, the next item waits in its final
// step until the output register frees up.
// Reset (rst_n low, synchronous) empties the queue and drops any result.
module fifo_with_priority_extract #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fwpe_pkg::OP_W-1:0]           in_opcode,
  input  logic [fwpe_pkg::PAY_W-1:0]          in_payload,
  input  logic signed [fwpe_pkg::PRIO_W-1:0]  in_priority,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fwpe_pkg::STS_W-1:0]          out_status,
  output logic [fwpe_pkg::PAY_W-1:0]          out_payload,
  output logic signed [fwpe_pkg::PRIO_W-1:0]  out_priority,
  output logic [fwpe_pkg::OCC_W-1:0]          out_occupancy
);

  import fwpe_pkg::*;

`include "fifo_with_priority_extract_defines.svh"

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam logic [BIT_IDX_W-1:0] TOP_BIT = BIT_IDX_W'(PRIO_W - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_APPLY  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [SW-1:0]         push_pay_r;
  logic signed [PRIO_W-1:0] push_pri_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]      status_r;
  logic [PAY_W-1:0]      out_pay_r;
  logic [PRIO_W-1:0]     out_pri_r;
  logic [OCC_W-1:0]      occ_r;

  logic                  accept, apply_go, is_rem, is_empty, is_full;
  logic                  any_hit;
  logic [STS_W-1:0]      status_nxt;
  fwpe_ctl_t             ctl;

  // per-cell wiring
  logic [SW-1:0]            cell_pay  [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] cell_pri  [QUEUE_DEPTH];
  logic [SW-1:0]            sel_pay_v [QUEUE_DEPTH];
  logic [PRIO_W-1:0]        sel_pri_v [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cand_v, hit_v, pre_v;
  logic [QUEUE_DEPTH-1:0]   pay_col [SW];
  logic [QUEUE_DEPTH-1:0]   pri_col [PRIO_W];
  logic [SW-1:0]            sel_pay;
  logic [PRIO_W-1:0]        sel_pri;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign is_rem   = (op_r == OP_POP) || (op_r == OP_EXTRACT);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(QUEUE_DEPTH));
  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // some candidate has a one in the key bit under test
  assign any_hit = |hit_v;

  // broadcast control to the cell row
  always_comb begin
    ctl         = '0;
    ctl.seed_x  = accept && (in_opcode == OP_EXTRACT);
    ctl.seed_p  = accept && (in_opcode == OP_POP);
    ctl.elim    = (state_r == S_SEARCH);
    ctl.bit_idx = bit_r;
    ctl.shift   = apply_go && is_rem && !is_empty;
    ctl.push    = apply_go && (op_r == OP_PUSH) && !is_full;
  end

  // the cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     pre_prev_w;
    logic [SW-1:0]            nb_pay_w;
    logic signed [PRIO_W-1:0] nb_pri_w;

    if (i == 0) begin : g_head
      assign pre_prev_w = 1'b0;
    end else begin : g_body
      assign pre_prev_w = pre_v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb_pay_w = cell_pay[i];
      assign nb_pri_w = cell_pri[i];
    end else begin : g_inner
      assign nb_pay_w = cell_pay[i+1];
      assign nb_pri_w = cell_pri[i+1];
    end

    fwpe_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (i),
      .SLOT_BITS   (SW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .any_hit      (any_hit),
      .count        (count_r),
      .pre_self     (pre_v[i]),
      .pre_prev     (pre_prev_w),
      .nb_payload   (nb_pay_w),
      .nb_prio      (nb_pri_w),
      .push_payload (push_pay_r),
      .push_prio    (push_pri_r),
      .payload      (cell_pay[i]),
      .prio         (cell_pri[i]),
      .cand         (cand_v[i]),
      .hit          (hit_v[i]),
      .sel_payload  (sel_pay_v[i]),
      .sel_prio     (sel_pri_v[i])
    );
  end

  // slots at or after the first remaining candidate
  fwpe_prefix #(
    .WIDTH (QUEUE_DEPTH)
  ) u_prefix (
    .vec_in  (cand_v),
    .vec_out (pre_v)
  );

  // OR together the single selected entry (all other cells drive zero)
  always_comb begin
    for (int b = 0; b < SW; b++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        pay_col[b][i] = sel_pay_v[i][b];
      end
    end
    for (int b = 0; b < PRIO_W; b++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        pri_col[b][i] = sel_pri_v[i][b];
      end
    end
    for (int b = 0; b < SW; b++) begin
      sel_pay[b] = |pay_col[b];
    end
    for (int b = 0; b < PRIO_W; b++) begin
      sel_pri[b] = |pri_col[b];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_opcode;
          bit_nxt = TOP_BIT;
          if ((in_opcode == OP_EXTRACT) && !is_empty) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_SEARCH: begin
        bit_nxt = bit_r - BIT_IDX_W'(1);
        if (bit_r == '0) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // fill level and status of the item being finished
  always_comb begin
    count_nxt  = count_r;
    status_nxt = STS_OK;
    if (op_r == OP_PUSH) begin
      if (is_full) begin
        status_nxt = STS_FULL;
      end else if (apply_go) begin
        count_nxt = count_r + CW'(1);
      end
    end else if (is_rem) begin
      if (is_empty) begin
        status_nxt = STS_EMPTY;
      end else if (apply_go) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  // result valid: set when an item finishes, cleared when taken
  always_comb begin
    priority if (apply_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_PUSH;
      bit_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      bit_r       <= bit_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // captured push data and the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      push_pay_r <= in_payload[SW-1:0];
      push_pri_r <= in_priority;
    end
    if (apply_go) begin
      status_r  <= status_nxt;
      out_pay_r <= (is_rem && !is_empty) ? PAY_W'(sel_pay) : '0;
      out_pri_r <= (is_rem && !is_empty) ? sel_pri : '0;
      occ_r     <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_payload   = out_pay_r;
  assign out_priority  = out_pri_r;
  assign out_occupancy = occ_r;

  // checks
  `FWPE_ASSERT(a_count_bound, count_r <= CW'(QUEUE_DEPTH), "fill level above queue depth")
  `FWPE_ASSERT_IMP(a_one_removed, (state_r == S_APPLY) && is_rem && !is_empty,
    $onehot(pre_v & ~(pre_v << 1)), "removal does not select exactly one slot")
  `FWPE_ASSERT_IMP(a_search_alive, state_r == S_SEARCH, cand_v != '0,
    "max search lost every candidate")
  `FWPE_ASSERT_IMP(a_count_at_apply, count_r != $past(count_r), $past(apply_go),
    "fill level changed outside the apply step")

endmodule
